// ===== rtl/core/tcfp_pkg.sv =====
// Shared types and constants for the torque command frame parser.
package tcfp_pkg;

    localparam int FRAME_LEN = 16;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int TORQUE_W  = 14;
    localparam int RAW_W     = 19;

    localparam logic [TORQUE_W-1:0] LIMIT_RESET = 14'd1500;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_T     = 8'd84;
    localparam logic [7:0] CH_L     = 8'd76;
    localparam logic [7:0] CH_R     = 8'd82;
    localparam logic [7:0] CH_M     = 8'd77;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_ONE   = 8'd49;
    localparam logic [7:0] CH_TWO   = 8'd50;
    localparam logic [7:0] CH_SIX   = 8'd54;

    localparam logic [2:0] MODE_STOP  = 3'd0;
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;
    localparam logic [1:0] TECH_STOOP = 2'd0;
    localparam logic [1:0] TECH_SQUAT = 2'd1;
    localparam logic [1:0] TECH_SEMI  = 2'd2;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_BAD_TERM  = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_WRONG_LEN = 2'd3
    } frame_status_t;

    typedef logic [TORQUE_W-1:0]     torque_t;
    typedef logic signed [RAW_W-1:0] raw_torque_t;

    typedef struct packed {
        frame_status_t status;
        logic          left_upd;
        logic          right_upd;
        logic          motion_upd;
        raw_torque_t   left_raw;
        raw_torque_t   right_raw;
        logic [2:0]    mode;
        logic [1:0]    side;
        logic [1:0]    technique;
    } frame_cmd_t;

    typedef struct packed {
        frame_status_t status;
        torque_t       left;
        torque_t       right;
        logic          left_upd;
        logic          right_upd;
        logic          motion_upd;
        logic [2:0]    mode;
        logic [2:0]    prev_mode;
        logic [1:0]    side;
        logic [1:0]    technique;
    } frame_result_t;

endpackage

// ===== rtl/core/tcfp_fifo.sv =====
// Two-entry queue of packed words.
module tcfp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/tcfp_front.sv =====
// Front end: byte framing, line store and frame classification.
module tcfp_front #(
    parameter int BUFFER_LEN = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    output logic                 cmd_push,
    output tcfp_pkg::frame_cmd_t cmd
);

    import tcfp_pkg::*;

    localparam int CW = $clog2(BUFFER_LEN + 1);

    logic [7:0]    store_reg [FRAME_LEN];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          cr_reg;
    logic          cr_next;
    logic          store_we;
    frame_status_t status;
    logic          good;

    function automatic raw_torque_t raw_value(input logic [7:0] c0, input logic [7:0] c1,
                                              input logic [7:0] c2, input logic [7:0] c3);
        logic signed [8:0] d0;
        logic signed [8:0] d1;
        logic signed [8:0] d2;
        logic signed [8:0] d3;
        d0 = $signed({1'b0, c0}) - 9'sd48;
        d1 = $signed({1'b0, c1}) - 9'sd48;
        d2 = $signed({1'b0, c2}) - 9'sd48;
        d3 = $signed({1'b0, c3}) - 9'sd48;
        return raw_torque_t'(d0) * RAW_W'(1000) + raw_torque_t'(d1) * RAW_W'(100)
             + raw_torque_t'(d2) * RAW_W'(10) + raw_torque_t'(d3);
    endfunction

    function automatic logic [2:0] mode_of(input logic [7:0] c);
        if (c >= CH_ONE && c <= CH_SIX)
            return c[2:0];
        return MODE_STOP;
    endfunction

    function automatic logic [1:0] side_of(input logic [7:0] c);
        if (c == CH_ONE)
            return SIDE_LEFT;
        if (c == CH_TWO)
            return SIDE_RIGHT;
        return SIDE_NONE;
    endfunction

    function automatic logic [1:0] tech_of(input logic [7:0] c);
        if (c == CH_ZERO)
            return TECH_STOOP;
        if (c == CH_TWO)
            return TECH_SEMI;
        return TECH_SQUAT;
    endfunction

    always_comb
    begin
        count_next = count_reg;
        cr_next    = cr_reg;
        store_we   = 1'b0;
        cmd_push   = 1'b0;
        status     = ST_ACCEPTED;
        if (accept)
        begin
            priority if (cr_reg)
            begin
                cr_next    = 1'b0;
                count_next = '0;
                cmd_push   = 1'b1;
                priority if (rx_byte != CH_LF)
                    status = ST_BAD_TERM;
                else if (count_reg != CW'(FRAME_LEN))
                    status = ST_WRONG_LEN;
                else
                    status = ST_ACCEPTED;
            end
            else if (rx_byte == CH_CR)
            begin
                cr_next = 1'b1;
            end
            else if (count_reg < CW'(BUFFER_LEN))
            begin
                store_we   = (count_reg < CW'(FRAME_LEN));
                count_next = count_reg + 1'b1;
            end
            else
            begin
                count_next = '0;
                cmd_push   = 1'b1;
                status     = ST_OVERFLOW;
            end
        end
    end

    assign good = (status == ST_ACCEPTED);

    always_comb
    begin
        cmd.status     = status;
        cmd.left_upd   = good && store_reg[0] == CH_T && store_reg[1] == CH_L;
        cmd.right_upd  = good && store_reg[6] == CH_T && store_reg[7] == CH_R;
        cmd.motion_upd = good && store_reg[12] == CH_M;
        cmd.left_raw   = raw_value(store_reg[2], store_reg[3], store_reg[4], store_reg[5]);
        cmd.right_raw  = raw_value(store_reg[8], store_reg[9], store_reg[10], store_reg[11]);
        cmd.mode       = mode_of(store_reg[13]);
        cmd.side       = side_of(store_reg[14]);
        cmd.technique  = tech_of(store_reg[15]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            cr_reg    <= cr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

// ===== rtl/core/tcfp_back.sv =====
// Back end: torque clamping and reference/mode register update.
module tcfp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tcfp_pkg::torque_t       limit,
    input  logic                    cmd_empty,
    input  tcfp_pkg::frame_cmd_t    cmd,
    output logic                    cmd_pop,
    input  logic                    res_full,
    output logic                    res_push,
    output tcfp_pkg::frame_result_t res
);

    import tcfp_pkg::*;

    torque_t    left_reg;
    torque_t    left_next;
    torque_t    right_reg;
    torque_t    right_next;
    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [2:0] prev_mode_reg;
    logic [2:0] prev_mode_next;
    logic [1:0] side_reg;
    logic [1:0] side_next;
    logic [1:0] tech_reg;
    logic [1:0] tech_next;

    function automatic torque_t clamp(input raw_torque_t v, input torque_t lim);
        priority if (v >= $signed({{(RAW_W-TORQUE_W){1'b0}}, lim}))
            return lim;
        else if (v < 0)
            return '0;
        else
            return v[TORQUE_W-1:0];
    endfunction

    assign cmd_pop  = !cmd_empty && !res_full;
    assign res_push = cmd_pop;

    always_comb
    begin
        left_next      = left_reg;
        right_next     = right_reg;
        mode_next      = mode_reg;
        prev_mode_next = prev_mode_reg;
        side_next      = side_reg;
        tech_next      = tech_reg;
        if (cmd_pop)
        begin
            if (cmd.left_upd)
                left_next = clamp(cmd.left_raw, limit);
            if (cmd.right_upd)
                right_next = clamp(cmd.right_raw, limit);
            if (cmd.motion_upd)
            begin
                prev_mode_next = mode_reg;
                mode_next      = cmd.mode;
                side_next      = cmd.side;
                tech_next      = cmd.technique;
            end
        end
    end

    always_comb
    begin
        res.status     = cmd.status;
        res.left       = left_next;
        res.right      = right_next;
        res.left_upd   = cmd.left_upd;
        res.right_upd  = cmd.right_upd;
        res.motion_upd = cmd.motion_upd;
        res.mode       = mode_next;
        res.prev_mode  = prev_mode_next;
        res.side       = side_next;
        res.technique  = tech_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            mode_reg      <= MODE_STOP;
            prev_mode_reg <= MODE_STOP;
            side_reg      <= SIDE_NONE;
            tech_reg      <= TECH_STOOP;
        end
        else
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            mode_reg      <= mode_next;
            prev_mode_reg <= prev_mode_next;
            side_reg      <= side_next;
            tech_reg      <= tech_next;
        end
    end

endmodule

// ===== rtl/core/torque_command_frame_parser.sv =====
// A result is visible once its frame has passed both registered queues. Throughput: one
// byte per cycle while full is low; the back end retires one frame per cycle while a
// frame waits and the output queue is not full. The front end hands frames to the back
// end through a 2-entry queue; results wait in a 2-entry output queue. full follows the
// front queue only. Reset: asynchronous, active low; the stored limit returns to 1500,
// references and modes to zero, framing restarts with an empty line. No clearing pass.
module torque_command_frame_parser #(
    parameter int BUFFER_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] torque_limit,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  frame_status,
    output logic [13:0] torque_left,
    output logic [13:0] torque_right,
    output logic        left_updated,
    output logic        right_updated,
    output logic        motion_updated,
    output logic [2:0]  motion_mode,
    output logic [2:0]  previous_mode,
    output logic [1:0]  asym_side,
    output logic [1:0]  bend_technique
);

    import tcfp_pkg::*;

    torque_t       limit_reg;
    torque_t       limit_next;
    logic          in_accept;
    logic          cmd_push;
    frame_cmd_t    cmd_in;
    frame_cmd_t    cmd_out;
    logic          cmd_empty;
    logic          cmd_pop;
    logic          res_full;
    logic          res_push;
    frame_result_t res_in;
    frame_result_t res_out;

    assign cfg_ready  = 1'b1;
    assign in_accept  = push && !full;
    assign limit_next = (cfg_valid && cfg_ready) ? torque_limit : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    tcfp_front #(
        .BUFFER_LEN (BUFFER_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .rx_byte  (rx_byte),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    tcfp_fifo #(
        .WIDTH ($bits(frame_cmd_t))
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    tcfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    tcfp_fifo #(
        .WIDTH ($bits(frame_result_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign frame_status   = res_out.status;
    assign torque_left    = res_out.left;
    assign torque_right   = res_out.right;
    assign left_updated   = res_out.left_upd;
    assign right_updated  = res_out.right_upd;
    assign motion_updated = res_out.motion_upd;
    assign motion_mode    = res_out.mode;
    assign previous_mode  = res_out.prev_mode;
    assign asym_side      = res_out.side;
    assign bend_technique = res_out.technique;

`ifndef NO_ASSERTIONS
    a_cmd_from_transfer : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> in_accept)
        else $error("frame queued without a byte transfer");

    a_result_from_back : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(res_push))
        else $error("result appeared without back end retiring a frame");

    a_flags_only_accepted : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_status != ST_ACCEPTED) |->
            (!left_updated && !right_updated && !motion_updated))
        else $error("update flag set in a rejected frame");

    a_prev_tracks_mode : assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_in.motion_upd) |=> (res_in.prev_mode == $past(res_in.mode) ||
            !res_push || !res_in.motion_upd))
        else $error("previous mode does not follow the last mode");
`endif

endmodule
